// ===== rtl/core/block_min_max_mean_median_defines.svh =====
// assertion macros for the block statistics unit
`ifndef BLOCK_MIN_MAX_MEAN_MEDIAN_DEFINES_SVH
`define BLOCK_MIN_MAX_MEAN_MEDIAN_DEFINES_SVH

// checked only while out of reset
`define BMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BMM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bmm_pkg.sv =====
// shared constants and control types of the block statistics unit
`default_nettype none
package bmm_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int BIT_W       = (SAMPLE_BITS > 2) ? $clog2(SAMPLE_BITS) : 1;
    localparam int DCNT_W      = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_STEP,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sel_init;
        logic scan;
        logic step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic bit_zero;
        logic div_done;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/block_min_max_mean_median.sv =====
// top level of the block statistics unit
// Takes one sample per cycle until the transfer that carries last_sample. It then searches
// the sample store for the median one result bit per pass (SAMPLE_BITS passes over the
// single store read port), then divides the sum by the count at one quotient bit per cycle.
// The next block's samples are taken as soon as the result sits in the output register.
`default_nettype none
module block_min_max_mean_median import bmm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_value,
    input  wire logic                   i_last_sample,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [SAMPLE_BITS-1:0] o_max_value,
    output logic      [IDX_W-1:0]       o_max_position,
    output logic      [SAMPLE_BITS-1:0] o_min_value,
    output logic      [IDX_W-1:0]       o_min_position,
    output logic      [SAMPLE_BITS-1:0] o_mean_value,
    output logic      [SAMPLE_BITS-1:0] o_median_value,
    output logic      [CNT_W-1:0]       o_sample_count,
    output logic                        o_overflow_flag
);
    t_cmd    cmd;
    t_status status;

    bmm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_sample(i_last_sample),
        .o_ready      (o_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    bmm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample_value (i_sample_value),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_max_value    (o_max_value),
        .o_max_position (o_max_position),
        .o_min_value    (o_min_value),
        .o_min_position (o_min_position),
        .o_mean_value   (o_mean_value),
        .o_median_value (o_median_value),
        .o_sample_count (o_sample_count),
        .o_overflow_flag(o_overflow_flag)
    );
endmodule
`default_nettype wire

// ===== rtl/core/bmm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module bmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bmm_ctrl.sv =====
// sequencer for load, median search, division and result hand-off
`default_nettype none
module bmm_ctrl import bmm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_last_sample,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_last_sample) begin
                    o_cmd.sel_init = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.bit_zero ? S_DIV_INIT : S_SCAN;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/bmm_datapath.sv =====
// running stats, sample store, bitwise median search, divider, output register
`default_nettype none
module bmm_datapath import bmm_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_status                      o_status,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_value,
    input  wire logic                    i_ready,
    output logic                         o_valid,
    output logic      [SAMPLE_BITS-1:0]  o_max_value,
    output logic      [IDX_W-1:0]        o_max_position,
    output logic      [SAMPLE_BITS-1:0]  o_min_value,
    output logic      [IDX_W-1:0]        o_min_position,
    output logic      [SAMPLE_BITS-1:0]  o_mean_value,
    output logic      [SAMPLE_BITS-1:0]  o_median_value,
    output logic      [CNT_W-1:0]        o_sample_count,
    output logic                         o_overflow_flag
);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SAMPLES);

    // running block state
    logic        [CNT_W-1:0]       r_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic        [IDX_W-1:0]       r_max_idx;
    logic        [IDX_W-1:0]       r_min_idx;
    logic                          r_drop;

    // median search
    logic [CNT_W-1:0]       r_addr;
    logic                   r_rd_vld;
    logic [BIT_W-1:0]       r_bit;
    logic [CNT_W-1:0]       r_cnt_lo;
    logic [CNT_W-1:0]       r_cnt_hi;
    logic [SAMPLE_BITS-1:0] r_med_lo;
    logic [SAMPLE_BITS-1:0] r_med_hi;

    // divider
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_neg;

    logic                          r_out_valid;

    logic signed [SAMPLE_BITS-1:0] sample_s;
    logic                          full;
    logic                          wr_en;
    logic                          rd_issue;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic [SAMPLE_BITS:0]          rd_off;
    logic [SAMPLE_BITS:0]          step_val;
    logic [SAMPLE_BITS:0]          test_lo;
    logic [SAMPLE_BITS:0]          test_hi;
    logic [CNT_W-1:0]              k_hi;
    logic [CNT_W-1:0]              k_lo;
    logic [CNT_W:0]                rem_sh;
    logic [CNT_W:0]                div_ext;
    logic                          rem_ge;
    logic [SAMPLE_BITS-1:0]        med_lo_s;
    logic [SAMPLE_BITS-1:0]        med_hi_s;
    logic [SAMPLE_BITS:0]          med_sum;
    logic [SAMPLE_BITS:0]          med_adj;
    logic [SAMPLE_BITS-1:0]        mean_mag;
    logic [SAMPLE_BITS-1:0]        mean_res;

    assign sample_s = $signed(i_sample_value);
    assign full     = (r_count == FULL_COUNT);
    assign wr_en    = i_cmd.load && !full;
    assign rd_issue = i_cmd.scan && (r_addr < r_count);

    bmm_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[IDX_W-1:0]),
        .i_wr_data(i_sample_value),
        .i_rd_en  (rd_issue),
        .i_rd_addr(r_addr[IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    // offset binary so unsigned compare orders signed samples
    assign rd_off   = {1'b0, ~rd_data[SAMPLE_BITS-1], rd_data[SAMPLE_BITS-2:0]};
    assign step_val = (SAMPLE_BITS+1)'(1) << r_bit;
    assign test_lo  = {1'b0, r_med_lo} + step_val;
    assign test_hi  = {1'b0, r_med_hi} + step_val;
    assign k_hi     = r_count >> 1;
    assign k_lo     = r_count[0] ? k_hi : k_hi - CNT_W'(1);

    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign div_ext = {1'b0, r_count};
    assign rem_ge  = (rem_sh >= div_ext);

    assign med_lo_s = {~r_med_lo[SAMPLE_BITS-1], r_med_lo[SAMPLE_BITS-2:0]};
    assign med_hi_s = {~r_med_hi[SAMPLE_BITS-1], r_med_hi[SAMPLE_BITS-2:0]};
    assign med_sum  = {med_lo_s[SAMPLE_BITS-1], med_lo_s}
                    + {med_hi_s[SAMPLE_BITS-1], med_hi_s};
    // halve toward zero
    assign med_adj  = med_sum + {{SAMPLE_BITS{1'b0}}, med_sum[SAMPLE_BITS]};

    assign mean_mag = r_quo[SAMPLE_BITS-1:0];
    assign mean_res = r_neg ? (~mean_mag + SAMPLE_BITS'(1)) : mean_mag;

    assign o_status.scan_done = (r_addr == r_count) && !r_rd_vld;
    assign o_status.bit_zero  = (r_bit == '0);
    assign o_status.div_done  = (r_dcnt == '0);
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_valid            = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_max_idx <= '0;
            r_min_idx <= '0;
            r_drop    <= 1'b0;
        end else if (i_cmd.load) begin
            if (!full) begin
                r_sum   <= r_sum + SUM_W'(sample_s);
                r_count <= r_count + CNT_W'(1);
                if (r_count == '0 || sample_s >= r_max) begin
                    r_max     <= sample_s;
                    r_max_idx <= r_count[IDX_W-1:0];
                end
                if (r_count == '0 || sample_s <= r_min) begin
                    r_min     <= sample_s;
                    r_min_idx <= r_count[IDX_W-1:0];
                end
            end else begin
                r_drop <= 1'b1;
            end
        end else if (i_cmd.out_load) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_max_idx <= '0;
            r_min_idx <= '0;
            r_drop    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_bit    <= '0;
        end else begin
            r_rd_vld <= rd_issue;
            if (i_cmd.sel_init || i_cmd.step) begin
                r_addr <= '0;
            end else if (rd_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (i_cmd.sel_init) begin
                r_bit <= BIT_W'(SAMPLE_BITS - 1);
            end else if (i_cmd.step) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_init) begin
            r_med_lo <= '0;
            r_med_hi <= '0;
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
        end else if (i_cmd.step) begin
            if (r_cnt_lo <= k_lo) begin
                r_med_lo <= test_lo[SAMPLE_BITS-1:0];
            end
            if (r_cnt_hi <= k_hi) begin
                r_med_hi <= test_hi[SAMPLE_BITS-1:0];
            end
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
        end else if (r_rd_vld) begin
            if (rd_off < test_lo) begin
                r_cnt_lo <= r_cnt_lo + CNT_W'(1);
            end
            if (rd_off < test_hi) begin
                r_cnt_hi <= r_cnt_hi + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? CNT_W'(rem_sh - div_ext) : rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_max_value     <= r_max;
            o_max_position  <= r_max_idx;
            o_min_value     <= r_min;
            o_min_position  <= r_min_idx;
            o_mean_value    <= mean_res;
            o_median_value  <= med_adj[SAMPLE_BITS:1];
            o_sample_count  <= r_count;
            o_overflow_flag <= r_drop;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bmm_checker.sv =====
// port level checks of the block statistics unit and their bind
`default_nettype none
`include "block_min_max_mean_median_defines.svh"
module bmm_checker import bmm_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [SAMPLE_BITS-1:0] o_max_value,
    input wire logic [IDX_W-1:0]       o_max_position,
    input wire logic [SAMPLE_BITS-1:0] o_min_value,
    input wire logic [SAMPLE_BITS-1:0] o_mean_value,
    input wire logic [CNT_W-1:0]       o_sample_count
);
    `BMM_ASSERT_RST(a_rst_no_valid, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `BMM_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_mean_value), "stalled result changed")
    `BMM_ASSERT(a_order, i_clk, i_rst_n, o_valid |-> ($signed(o_min_value) <= $signed(o_mean_value)) && ($signed(o_mean_value) <= $signed(o_max_value)), "mean outside min and max")
    `BMM_ASSERT(a_count, i_clk, i_rst_n, o_valid |-> (o_sample_count != '0) && ({1'b0, o_max_position} < o_sample_count), "count or position out of range")
endmodule

bind block_min_max_mean_median bmm_checker u_bmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_max_value   (o_max_value),
    .o_max_position(o_max_position),
    .o_min_value   (o_min_value),
    .o_mean_value  (o_mean_value),
    .o_sample_count(o_sample_count)
);
`default_nettype wire
